>>> src/bbh_pkg.sv
`default_nettype none
package bbh_pkg;

  localparam int unsigned SYMBOLS     = 128;
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned Cells      = SYMBOLS * SYMBOLS;
  localparam int unsigned IdxW       = $clog2(Cells);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    CmdStream = 2'd0,
    CmdEnd    = 2'd1,
    CmdRead   = 2'd2,
    CmdWrite  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OpInc      = 2'd0,
    OpRead     = 2'd1,
    OpReadZero = 2'd2,
    OpWrite    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                    kind;
    logic [IdxW-1:0]        idx;
    logic [COUNT_WIDTH-1:0] value;
  } op_t;

  function automatic logic sym_ok(logic [7:0] s);
    return {1'b0, s} < 9'(SYMBOLS);
  endfunction

  function automatic logic [IdxW-1:0] cell_index(logic [7:0] r, logic [7:0] c);
    logic [IdxW+8:0] full;
    full = (IdxW + 9)'(r) * (IdxW + 9)'(SYMBOLS) + (IdxW + 9)'(c);
    return full[IdxW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/bbh_front.sv
`default_nettype none
module bbh_front
  import bbh_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire cmd_e       cmd_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [6:0] row_symbol_i,
  input  wire logic [6:0] column_symbol_i,
  input  wire logic [31:0] load_value_i,
  input  wire logic       q_full_i,
  input  wire logic       busy_i,
  output logic            push_o,
  output op_t             op_o
);

  logic [7:0] prev_byte_q, prev_byte_d;
  logic       prev_valid_q, prev_valid_d;
  logic       accept;
  logic       need_op;
  logic [7:0] row_ext, col_ext;
  logic       rc_ok;

  assign in_ready_o = !q_full_i && !busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign row_ext    = {1'b0, row_symbol_i};
  assign col_ext    = {1'b0, column_symbol_i};
  assign rc_ok      = sym_ok(row_ext) && sym_ok(col_ext);

  always_comb begin
    prev_byte_d  = prev_byte_q;
    prev_valid_d = prev_valid_q;
    need_op      = 1'b0;
    op_o.kind    = OpInc;
    op_o.idx     = cell_index(row_ext, col_ext);
    op_o.value   = COUNT_WIDTH'(load_value_i);
    unique case (cmd_i)
      CmdStream: begin
        need_op      = prev_valid_q && sym_ok(prev_byte_q) && sym_ok(data_byte_i);
        op_o.kind    = OpInc;
        op_o.idx     = cell_index(prev_byte_q, data_byte_i);
        prev_byte_d  = data_byte_i;
        prev_valid_d = 1'b1;
      end
      CmdEnd: begin
        prev_valid_d = 1'b0;
      end
      CmdRead: begin
        need_op   = 1'b1;
        op_o.kind = rc_ok ? OpRead : OpReadZero;
      end
      CmdWrite: begin
        need_op   = rc_ok;
        op_o.kind = OpWrite;
      end
      default: begin
        need_op = 1'b0;
      end
    endcase
  end

  assign push_o = accept && need_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_byte_q  <= '0;
      prev_valid_q <= 1'b0;
    end else if (accept) begin
      prev_byte_q  <= prev_byte_d;
      prev_valid_q <= prev_valid_d;
    end
  end

endmodule
`default_nettype wire

>>> src/bbh_queue.sv
`default_nettype none
module bbh_queue
  import bbh_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output op_t       head_o
);

  op_t              slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_pop;

  assign full_o  = count_q == QCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bbh_back.sv
`default_nettype none
module bbh_back
  import bbh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  wire op_t         head_i,
  output logic             pop_o,
  output logic             busy_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      pair_count_o
);

  logic [COUNT_WIDTH-1:0] mem [Cells];

  logic                   clearing_q;
  logic [IdxW-1:0]        clr_idx_q;
  op_t                    s1_q;
  logic                   s1_valid_q;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   fwd_valid_q;
  logic [IdxW-1:0]        fwd_idx_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic                   out_valid_q;
  logic [31:0]            out_data_q;

  logic                   out_free;
  logic                   s1_is_read;
  logic                   s1_write;
  logic                   advance;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] new_val;
  logic [COUNT_WIDTH-1:0] rd_result;

  assign busy_o      = clearing_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_is_read  = s1_valid_q && (s1_q.kind == OpRead || s1_q.kind == OpReadZero);
  assign advance     = !clearing_q && (!s1_is_read || out_free);
  assign pop_o       = advance && head_valid_i;
  assign s1_write    = s1_valid_q && (s1_q.kind == OpInc || s1_q.kind == OpWrite);
  assign cur         = (fwd_valid_q && fwd_idx_q == s1_q.idx) ? fwd_data_q : rd_q;

  always_comb begin
    new_val   = cur;
    rd_result = '0;
    unique case (s1_q.kind)
      OpInc:      new_val   = (cur == CountMax) ? cur : cur + 1'b1;
      OpWrite:    new_val   = s1_q.value;
      OpRead:     rd_result = cur;
      OpReadZero: rd_result = '0;
      default:    new_val   = cur;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_idx_q] <= '0;
    end else if (s1_write) begin
      mem[s1_q.idx] <= new_val;
    end
    if (pop_o) begin
      rd_q <= mem[head_i.idx];
      s1_q <= head_i;
    end
    if (s1_write) begin
      fwd_idx_q  <= s1_q.idx;
      fwd_data_q <= new_val;
    end
    if (s1_is_read && out_free) begin
      out_data_q <= 32'(rd_result);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == IdxW'(Cells - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid_q <= head_valid_i;
      end
      if (s1_write) begin
        fwd_valid_q <= 1'b1;
      end
      if (s1_is_read && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = out_data_q;

  a_no_op_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing_q |-> !s1_valid_q && !pop_o
  ) else $error("operation in flight during table clear");

  a_stall_holds_read : assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_valid_q && !advance |=> $stable(rd_q)
  ) else $error("read data changed while stage stalled");

  a_fwd_tracks_write : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_write |=> fwd_valid_q && fwd_idx_q == $past(s1_q.idx)
  ) else $error("forwarding register missed last write");

endmodule
`default_nettype wire

>>> src/byte_bigram_histogram_top.sv
// Byte bigram histogram.
// Input stream (s_axis_*): one command per transaction. tuser carries the
// command: stream byte, end of stream, read counter, write counter.
// tdata carries data_byte, row_symbol, column_symbol and load_value.
// Output stream (m_axis_*): one transaction per read command, carrying
// the 32-bit pair_count, in command order.
// Throughput: one command per cycle while the command queue has room and no
// clear is running. Counter updates go through a two-stage read-modify-write
// on the dual-port counter RAM, with forwarding of the last write, so
// back-to-back bytes hitting the same pair do not stall.
// Reset: the previous-byte chain is broken and the 16384-entry counter RAM
// is cleared one entry per cycle; s_axis_tready stays low until the clear ends.
// Stall: while m_axis_tready is low one result waits in the output register;
// the 4-entry command queue keeps taking commands until it fills, then
// s_axis_tready drops.
`default_nettype none
module byte_bigram_histogram_top
  import bbh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [14:8] row_symbol, [21:15] column_symbol,
  // [53:22] load_value, [55:54] zero
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] pair_count
  output logic [31:0]      m_axis_tdata
);

  logic q_full, q_valid, push, pop, busy;
  op_t  op, head;
  cmd_e cmd;

  assign cmd = cmd_e'(s_axis_tuser);

  bbh_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .cmd_i           (cmd),
    .data_byte_i     (s_axis_tdata[7:0]),
    .row_symbol_i    (s_axis_tdata[14:8]),
    .column_symbol_i (s_axis_tdata[21:15]),
    .load_value_i    (s_axis_tdata[53:22]),
    .q_full_i        (q_full),
    .busy_i          (busy),
    .push_o          (push),
    .op_o            (op)
  );

  bbh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .head_o  (head)
  );

  bbh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .busy_o       (busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pair_count_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bbh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = CmdEnd;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic [COUNT_WIDTH-1:0] pair_hist [Cells];
  logic [7:0]             last_byte;
  logic                   last_valid;
  logic [31:0]            expected_counts [$];

  bit          gaps_on = 1'b1;
  int          err_count = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  prev_sent = 8'h61;

  byte_bigram_histogram_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 8) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected pair_count, expected none, got %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        if (m_axis_tdata !== expected_counts[0]) begin
          $display("%0t: pair_count mismatch, expected %h, got %h",
                   $time, expected_counts[0], m_axis_tdata);
          err_count++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  function automatic void predict_item(cmd_e cmd, logic [7:0] b, logic [6:0] r,
                                       logic [6:0] c, logic [31:0] v);
    logic [IdxW-1:0] k;
    case (cmd)
      CmdStream: begin
        if (last_valid && last_byte < SYMBOLS && b < SYMBOLS) begin
          k = {last_byte[6:0], b[6:0]};
          if (pair_hist[k] != CountMax) pair_hist[k] = pair_hist[k] + 1'b1;
        end
        last_byte  = b;
        last_valid = 1'b1;
      end
      CmdEnd: last_valid = 1'b0;
      CmdRead: expected_counts.insert(expected_counts.size(), pair_hist[{r, c}]);
      default: pair_hist[{r, c}] = v;
    endcase
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [7:0] b, input logic [6:0] r,
                           input logic [6:0] c, input logic [31:0] v);
    while (gaps_on && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, v, c, r, b};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(cmd, b, r, c, v);
  endtask

  task automatic send_stream(input logic [7:0] b);
    send_item(CmdStream, b, 7'($urandom), 7'($urandom), $urandom);
  endtask

  task automatic send_read(input logic [6:0] r, input logic [6:0] c);
    send_item(CmdRead, 8'($urandom), r, c, $urandom);
  endtask

  task automatic send_write(input logic [6:0] r, input logic [6:0] c, input logic [31:0] v);
    send_item(CmdWrite, 8'($urandom), r, c, v);
  endtask

  function automatic logic [7:0] pick_text_byte();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return prev_sent;
    if (sel < 60) return 8'(8'h61 + $urandom_range(7));
    if (sel < 85) return 8'($urandom_range(127));
    if (sel < 90) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [6:0] pick_symbol();
    if ($urandom_range(99) < 60) return 7'(7'h61 + $urandom_range(7));
    return 7'($urandom);
  endfunction

  task automatic send_random_item();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 65) begin
      prev_sent = pick_text_byte();
      send_stream(prev_sent);
    end else if (sel < 72) begin
      send_item(CmdEnd, 8'($urandom), 7'($urandom), 7'($urandom), $urandom);
    end else if (sel < 88) begin
      send_read(pick_symbol(), pick_symbol());
    end else begin
      v = ($urandom_range(99) < 40) ? (32'hFFFF_FFFF - $urandom_range(2)) : $urandom;
      send_write(pick_symbol(), pick_symbol(), v);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_pairs();
    send_stream(8'h00);
    send_stream(8'h00);
    send_stream(8'h7F);
    send_stream(8'h7F);
    send_stream(8'h80);
    send_stream(8'h41);
    send_stream(8'hFF);
    send_stream(8'h42);
    send_item(CmdEnd, 8'h00, 7'h00, 7'h00, 32'h0);
    send_stream(8'h43);
    send_read(7'h00, 7'h00);
    send_stream(8'h44);
    send_write(7'h05, 7'h06, 32'hFFFF_FFFF);
    send_item(CmdEnd, 8'hFF, 7'h7F, 7'h7F, 32'hFFFF_FFFF);
    send_stream(8'h05);
    send_stream(8'h06);
    send_read(7'h05, 7'h06);
    send_write(7'h7F, 7'h7F, 32'hFFFF_FFFE);
    send_stream(8'h7F);
    send_stream(8'h7F);
    send_stream(8'h7F);
    send_read(7'h7F, 7'h7F);
    send_read(7'h43, 7'h44);
    send_write(7'h00, 7'h00, 32'h0000_0000);
    send_read(7'h00, 7'h00);
    send_read(7'h00, 7'h7F);
  endtask

  task automatic test_random_text(input int unsigned n);
    repeat (n) send_random_item();
  endtask

  task automatic test_back_to_back(input int unsigned n);
    gaps_on = 1'b0;
    repeat (n) send_random_item();
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (pair_hist[i]) pair_hist[i] = '0;
    last_byte  = 8'h00;
    last_valid = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_pairs();
    test_random_text(350);
    wait_drain();
    test_back_to_back(200);
    test_random_text(250);
    wait_drain();
    gaps_on = 1'b0;
    repeat (10) @(posedge clk_i);
    if (expected_counts.size() != 0) begin
      $display("%0t: %0d pair_count results never arrived", $time, expected_counts.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
